### hw/rtl/delayed_pulse_train_with_rampdown_core_assert.svh
// assertion macros used by the checker in dptr_checker.sv
`ifndef DELAYED_PULSE_TRAIN_WITH_RAMPDOWN_CORE_ASSERT_SVH
`define DELAYED_PULSE_TRAIN_WITH_RAMPDOWN_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DPTR_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dptr assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DPTR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dptr assertion failed");

`endif

### hw/rtl/dptr_pkg.sv
package dptr_pkg;

    // fixed field widths
    localparam int MODE_W      = 2;
    localparam int STEPS_W     = 10;
    localparam int INT_W       = 10;
    localparam int POWER_W     = 7;
    localparam int POWER_SHIFT = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_USED_W  = INT_W + 2;
    localparam int CFG_IDX_W   = 3;

    localparam logic [POWER_W-1:0] MAX_POWER     = 7'd100;
    localparam logic [INT_W-1:0]   MAX_DRIVE_INT = 10'd800;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK        = 2'd0,
        MODE_START       = 2'd1,
        MODE_CANCEL      = 2'd2,
        MODE_CANCEL_RAMP = 2'd3
    } mode_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_EN  = 3'd5;

endpackage

### hw/rtl/dptr_div.sv
module dptr_div #(
    parameter int DIVIDEND_W = 18
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DIVIDEND_W-1:0]        dividend,
    input  logic [dptr_pkg::STEPS_W-1:0] divisor,
    output logic                         done,
    output logic [DIVIDEND_W-1:0]        quotient
);

    localparam int DVW = dptr_pkg::STEPS_W;
    localparam int CW  = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DVW-1:0]        rem_reg;
    logic [DVW-1:0]        dvs_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           fits;
    logic [DVW-1:0] rem_new;

    // restoring division, one quotient bit per cycle
    assign trial   = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = trial - {1'b0, dvs_reg};
    assign fits    = trial >= {1'b0, dvs_reg};
    assign rem_new = fits ? diff[DVW-1:0] : trial[DVW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CW'(DIVIDEND_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg  <= {quo_reg[DIVIDEND_W-2:0], fits};
                rem_reg  <= rem_new;
                cnt_reg  <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/dptr_cfg.sv
module dptr_cfg #(
    parameter int TICK_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [dptr_pkg::CFG_IDX_W-1:0] index,
    input  logic [TICK_BITS-1:0]           data,
    output logic [TICK_BITS-1:0]           delay_ticks,
    output logic [TICK_BITS-1:0]           duration_ticks,
    output logic [TICK_BITS-1:0]           on_ticks,
    output logic [TICK_BITS-1:0]           off_ticks,
    output logic [dptr_pkg::POWER_W-1:0]   power_percent,
    output logic                           ramp_enable
);

    logic [TICK_BITS-1:0]         delay_reg;
    logic [TICK_BITS-1:0]         duration_reg;
    logic [TICK_BITS-1:0]         on_reg;
    logic [TICK_BITS-1:0]         off_reg;
    logic [dptr_pkg::POWER_W-1:0] power_reg;
    logic                         ramp_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= '0;
            duration_reg <= '0;
            on_reg       <= '0;
            off_reg      <= '0;
            power_reg    <= '0;
            ramp_en_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (index)
                dptr_pkg::REG_DELAY:    delay_reg    <= data;
                dptr_pkg::REG_DURATION: duration_reg <= data;
                dptr_pkg::REG_ON:       on_reg       <= data;
                dptr_pkg::REG_OFF:      off_reg      <= data;
                dptr_pkg::REG_POWER:    power_reg    <= data[dptr_pkg::POWER_W-1:0];
                dptr_pkg::REG_RAMP_EN:  ramp_en_reg  <= data[0];
                default:                ;
            endcase
        end
    end

    assign delay_ticks    = delay_reg;
    assign duration_ticks = duration_reg;
    assign on_ticks       = on_reg;
    assign off_ticks      = off_reg;
    assign power_percent  = power_reg;
    assign ramp_enable    = ramp_en_reg;

endmodule

### hw/rtl/delayed_pulse_train_with_rampdown_core.sv
// channel   direction  handshake             payload
// s_*       in         s_tvalid / s_tready   s_tuser: mode; s_tdata: ramp_steps
// m_*       out        m_tvalid / m_tready   m_tdata: drive_level, busy_res, start_error
// cfg_*     in         cfg_wr_en             cfg_index, cfg_data
//
// a tick on a running channel goes through S_EXEC, S_TICK and S_DONE; a taken start or
// a running cancel with ramp-down and a non-zero step count goes through S_EXEC, S_DIV
// (serial divider, one quotient bit a cycle) and S_DONE; any other item goes through S_EXEC
// and S_DONE; s_tready is high only while the sequencer is idle; a finished result sits in the
// output register so the next transfer is taken while it waits for m_tready
// rst_n clears the configuration and the whole channel state
module delayed_pulse_train_with_rampdown_core #(
    parameter int TICK_BITS = 24,
    parameter int FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dptr_pkg::IN_TDATA_W-1:0]  s_tdata,  // [9:0] ramp_steps
    input  logic [dptr_pkg::MODE_W-1:0]      s_tuser,  // [1:0] mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dptr_pkg::OUT_TDATA_W-1:0] m_tdata,  // [9:0] drive_level, [10] busy_res,
                                                       // [11] start_error
    input  logic                             cfg_wr_en,
    input  logic [dptr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [TICK_BITS-1:0]             cfg_data
);

    localparam int LW  = dptr_pkg::INT_W + FRAC_BITS;
    localparam int WW  = TICK_BITS + 1;
    localparam int SW  = dptr_pkg::STEPS_W;
    localparam int IW  = dptr_pkg::INT_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_TICK = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    // configuration
    logic [TICK_BITS-1:0]         cfg_delay;
    logic [TICK_BITS-1:0]         cfg_duration;
    logic [TICK_BITS-1:0]         cfg_on;
    logic [TICK_BITS-1:0]         cfg_off;
    logic [dptr_pkg::POWER_W-1:0] cfg_power;
    logic                         cfg_ramp_en;

    dptr_cfg #(
        .TICK_BITS (TICK_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (cfg_wr_en),
        .index          (cfg_index),
        .data           (cfg_data),
        .delay_ticks    (cfg_delay),
        .duration_ticks (cfg_duration),
        .on_ticks       (cfg_on),
        .off_ticks      (cfg_off),
        .power_percent  (cfg_power),
        .ramp_enable    (cfg_ramp_en)
    );

    // sequencer and item registers
    state_t            state_reg, state_next;
    dptr_pkg::mode_t   mode_reg, mode_next;
    logic [SW-1:0]     steps_reg, steps_next;
    logic              err_reg, err_next;

    // channel state
    logic              running_reg, running_next;
    logic              phase_on_reg, phase_on_next;
    logic              ramp_active_reg, ramp_active_next;
    logic [WW-1:0]     elapsed_reg, elapsed_next;
    logic [WW-1:0]     next_flip_reg, next_flip_next;
    logic [TICK_BITS-1:0] act_delay_reg, act_delay_next;
    logic [WW-1:0]     act_end_reg, act_end_next;
    logic [TICK_BITS-1:0] act_on_reg, act_on_next;
    logic [TICK_BITS-1:0] act_off_reg, act_off_next;
    logic [LW-1:0]     level_reg, level_next;
    logic [LW-1:0]     ramp_step_reg, ramp_step_next;
    logic [SW-1:0]     ramp_done_reg, ramp_done_next;
    logic [SW-1:0]     ramp_limit_reg, ramp_limit_next;
    logic [IW-1:0]     drive_reg, drive_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [IW-1:0]     out_drive_reg, out_drive_next;
    logic              out_busy_reg, out_busy_next;
    logic              out_err_reg, out_err_next;

    // shared divider
    logic              div_start;
    logic [LW-1:0]     div_dividend;
    logic              div_done;
    logic [LW-1:0]     div_quotient;

    dptr_div #(
        .DIVIDEND_W (LW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (steps_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // derived values
    logic [IW-1:0]     start_int;
    logic [LW-1:0]     start_level;
    logic [IW-1:0]     level_int;
    logic [WW-1:0]     elapsed_inc;
    logic [TICK_BITS-1:0] flip_add;
    logic [WW:0]       flip_sum;
    logic [WW-1:0]     flip_sat;
    logic [LW-1:0]     level_dec;
    logic              in_delay;
    logic              at_delay;
    logic              in_train;
    logic              flip_due;

    assign start_int    = {cfg_power, {dptr_pkg::POWER_SHIFT{1'b0}}};
    assign start_level  = {start_int, {FRAC_BITS{1'b0}}};
    assign level_int    = level_reg[LW-1:FRAC_BITS];
    assign elapsed_inc  = (elapsed_reg == {WW{1'b1}}) ? elapsed_reg : elapsed_reg + WW'(1);
    assign flip_add     = phase_on_reg ? act_off_reg : act_on_reg;
    assign flip_sum     = {1'b0, next_flip_reg} + {2'b00, flip_add};
    assign flip_sat     = flip_sum[WW] ? {WW{1'b1}} : flip_sum[WW-1:0];
    assign level_dec    = level_reg - ramp_step_reg;
    assign in_delay     = elapsed_reg < {1'b0, act_delay_reg};
    assign at_delay     = elapsed_reg == {1'b0, act_delay_reg};
    assign in_train     = elapsed_reg < act_end_reg;
    assign flip_due     = elapsed_reg >= next_flip_reg;
    assign div_dividend = (mode_reg == dptr_pkg::MODE_START) ? start_level : level_reg;

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        steps_next       = steps_reg;
        err_next         = err_reg;
        running_next     = running_reg;
        phase_on_next    = phase_on_reg;
        ramp_active_next = ramp_active_reg;
        elapsed_next     = elapsed_reg;
        next_flip_next   = next_flip_reg;
        act_delay_next   = act_delay_reg;
        act_end_next     = act_end_reg;
        act_on_next      = act_on_reg;
        act_off_next     = act_off_reg;
        level_next       = level_reg;
        ramp_step_next   = ramp_step_reg;
        ramp_done_next   = ramp_done_reg;
        ramp_limit_next  = ramp_limit_reg;
        drive_next       = drive_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_drive_next   = out_drive_reg;
        out_busy_next    = out_busy_reg;
        out_err_next     = out_err_reg;
        div_start        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = dptr_pkg::mode_t'(s_tuser);
                    steps_next = s_tdata[SW-1:0];
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                err_next   = 1'b0;
                state_next = S_DONE;
                case (mode_reg)
                    dptr_pkg::MODE_TICK:
                    begin
                        if (running_reg)
                        begin
                            elapsed_next = elapsed_inc;
                            state_next   = S_TICK;
                        end
                    end

                    dptr_pkg::MODE_START:
                    begin
                        if (cfg_power > dptr_pkg::MAX_POWER)
                        begin
                            err_next = 1'b1;
                        end
                        else if (cfg_duration != '0)
                        begin
                            level_next       = start_level;
                            ramp_limit_next  = steps_reg;
                            ramp_done_next   = '0;
                            ramp_active_next = cfg_ramp_en;
                            act_delay_next   = cfg_delay;
                            act_end_next     = {1'b0, cfg_delay} + {1'b0, cfg_duration};
                            act_on_next      = cfg_on;
                            act_off_next     = cfg_off;
                            elapsed_next     = '0;
                            phase_on_next    = 1'b1;
                            next_flip_next   = {1'b0, cfg_delay} + {1'b0, cfg_on};
                            running_next     = 1'b1;
                            if (cfg_delay == '0)
                            begin
                                drive_next = start_int;
                            end
                            if (steps_reg != '0)
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                            else
                            begin
                                ramp_step_next = '0;
                            end
                        end
                    end

                    default:
                    begin
                        // cancels only act on a running channel
                        if (running_reg)
                        begin
                            act_delay_next = '0;
                            act_end_next   = '0;
                            if (mode_reg == dptr_pkg::MODE_CANCEL)
                            begin
                                ramp_active_next = 1'b0;
                            end
                            else
                            begin
                                ramp_limit_next  = steps_reg;
                                ramp_done_next   = '0;
                                ramp_active_next = 1'b1;
                                if (steps_reg != '0)
                                begin
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                end
                                else
                                begin
                                    ramp_step_next = '0;
                                end
                            end
                        end
                    end
                endcase
            end

            S_TICK:
            begin
                state_next = S_DONE;
                if (!in_delay)
                begin
                    if (at_delay)
                    begin
                        drive_next = level_int;
                    end
                    if (in_train)
                    begin
                        if (flip_due)
                        begin
                            // a zero-length phase is skipped by holding the present one
                            if (phase_on_reg && (act_off_reg != '0))
                            begin
                                phase_on_next  = 1'b0;
                                next_flip_next = flip_sat;
                                drive_next     = '0;
                            end
                            else if (!phase_on_reg && (act_on_reg != '0))
                            begin
                                phase_on_next  = 1'b1;
                                next_flip_next = flip_sat;
                                drive_next     = level_int;
                            end
                        end
                    end
                    else if (ramp_active_reg && (level_reg > ramp_step_reg) &&
                             (ramp_done_reg < ramp_limit_reg))
                    begin
                        level_next     = level_dec;
                        drive_next     = level_dec[LW-1:FRAC_BITS];
                        ramp_done_next = ramp_done_reg + SW'(1);
                    end
                    else
                    begin
                        running_next     = 1'b0;
                        phase_on_next    = 1'b0;
                        ramp_active_next = 1'b0;
                        elapsed_next     = '0;
                        next_flip_next   = '0;
                        act_delay_next   = '0;
                        act_end_next     = '0;
                        act_on_next      = '0;
                        act_off_next     = '0;
                        level_next       = '0;
                        ramp_step_next   = '0;
                        ramp_done_next   = '0;
                        ramp_limit_next  = '0;
                        drive_next       = '0;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    ramp_step_next = div_quotient;
                    state_next     = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next   = 1'b1;
                    out_drive_next = drive_reg;
                    out_busy_next  = running_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= dptr_pkg::MODE_TICK;
            steps_reg       <= '0;
            err_reg         <= 1'b0;
            running_reg     <= 1'b0;
            phase_on_reg    <= 1'b0;
            ramp_active_reg <= 1'b0;
            elapsed_reg     <= '0;
            next_flip_reg   <= '0;
            act_delay_reg   <= '0;
            act_end_reg     <= '0;
            act_on_reg      <= '0;
            act_off_reg     <= '0;
            level_reg       <= '0;
            ramp_step_reg   <= '0;
            ramp_done_reg   <= '0;
            ramp_limit_reg  <= '0;
            drive_reg       <= '0;
            m_valid_reg     <= 1'b0;
            out_drive_reg   <= '0;
            out_busy_reg    <= 1'b0;
            out_err_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            steps_reg       <= steps_next;
            err_reg         <= err_next;
            running_reg     <= running_next;
            phase_on_reg    <= phase_on_next;
            ramp_active_reg <= ramp_active_next;
            elapsed_reg     <= elapsed_next;
            next_flip_reg   <= next_flip_next;
            act_delay_reg   <= act_delay_next;
            act_end_reg     <= act_end_next;
            act_on_reg      <= act_on_next;
            act_off_reg     <= act_off_next;
            level_reg       <= level_next;
            ramp_step_reg   <= ramp_step_next;
            ramp_done_reg   <= ramp_done_next;
            ramp_limit_reg  <= ramp_limit_next;
            drive_reg       <= drive_next;
            m_valid_reg     <= m_valid_next;
            out_drive_reg   <= out_drive_next;
            out_busy_reg    <= out_busy_next;
            out_err_reg     <= out_err_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(dptr_pkg::OUT_TDATA_W - dptr_pkg::OUT_USED_W){1'b0}},
                       out_err_reg, out_busy_reg, out_drive_reg};

endmodule

### hw/rtl/dptr_checker.sv
`include "delayed_pulse_train_with_rampdown_core_assert.svh"

module dptr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dptr_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // s_tready drops after every transfer, so no two transfers in a row
    `DPTR_ASSERT_NEXT(a_no_back_to_back, s_tvalid && s_tready, !s_tready)

    // drive never exceeds full power
    `DPTR_ASSERT_SAME(a_drive_range, m_tvalid, m_tdata[9:0] <= dptr_pkg::MAX_DRIVE_INT)

    // an idle channel always shows zero drive
    `DPTR_ASSERT_SAME(a_idle_drive_zero, m_tvalid && !m_tdata[10], m_tdata[9:0] == '0)

    // a stalled result holds
    `DPTR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind delayed_pulse_train_with_rampdown_core dptr_checker u_dptr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### sim/pulse_train_checker.sv
`timescale 1ns / 100ps

module pulse_train_checker
    import dptr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] ramp_steps
    input  logic [MODE_W-1:0]      s_tuser,   // [1:0] mode
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] drive_level, [10] busy_res,
                                              // [11] start_error
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [23:0]            cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     checked_count,
    output int                     refused_count,
    output int                     ramp_tick_count
);

    localparam int FRAC = 8;

    typedef struct packed {
        logic             start_error;
        logic             busy_res;
        logic [INT_W-1:0] drive_level;
    } pulse_result_t;

    pulse_result_t drive_expect_q[$];

    // shadow of the configuration registers
    logic [23:0]        delay_cfg;
    logic [23:0]        duration_cfg;
    logic [23:0]        on_cfg;
    logic [23:0]        off_cfg;
    logic [POWER_W-1:0] power_cfg;
    logic               ramp_en_cfg;

    // shadow of the channel
    logic        ch_running;
    logic        ch_phase_on;
    logic        ch_ramp_active;
    logic [24:0] ch_elapsed;
    logic [24:0] ch_next_flip;
    logic [23:0] ch_delay;
    logic [23:0] ch_duration;
    logic [23:0] ch_on;
    logic [23:0] ch_off;
    logic [17:0] ch_level;
    logic [17:0] ch_step;
    logic [9:0]  ch_ramp_count;
    logic [9:0]  ch_ramp_limit;
    logic [9:0]  ch_drive;

    function automatic logic [24:0] sat25(input logic [25:0] v);
        return v[25] ? '1 : v[24:0];
    endfunction

    function automatic void clear_channel_state();
        ch_running     = 1'b0;
        ch_phase_on    = 1'b0;
        ch_ramp_active = 1'b0;
        ch_elapsed     = '0;
        ch_next_flip   = '0;
        ch_delay       = '0;
        ch_duration    = '0;
        ch_on          = '0;
        ch_off         = '0;
        ch_level       = '0;
        ch_step        = '0;
        ch_ramp_count  = '0;
        ch_ramp_limit  = '0;
        ch_drive       = '0;
    endfunction

    function automatic pulse_result_t predict_pulse_step(input mode_t mode,
                                                         input logic [9:0] steps);
        pulse_result_t res;
        logic [25:0]   train_end;
        logic          err;
        err = 1'b0;
        case (mode)
            MODE_TICK:
            begin
                if (ch_running)
                begin
                    ch_elapsed = sat25({1'b0, ch_elapsed} + 26'd1);
                    if (ch_elapsed >= {1'b0, ch_delay})
                    begin
                        if (ch_elapsed == {1'b0, ch_delay})
                            ch_drive = ch_level[17:FRAC];
                        train_end = {2'b00, ch_delay} + {2'b00, ch_duration};
                        if ({1'b0, ch_elapsed} < train_end)
                        begin
                            if (ch_elapsed >= ch_next_flip)
                            begin
                                // a zero-length phase is skipped: the current one holds
                                if (ch_phase_on && ch_off != 0)
                                begin
                                    ch_phase_on  = 1'b0;
                                    ch_next_flip = sat25({1'b0, ch_next_flip} + {2'b00, ch_off});
                                    ch_drive     = '0;
                                end
                                else if (!ch_phase_on && ch_on != 0)
                                begin
                                    ch_phase_on  = 1'b1;
                                    ch_next_flip = sat25({1'b0, ch_next_flip} + {2'b00, ch_on});
                                    ch_drive     = ch_level[17:FRAC];
                                end
                            end
                        end
                        else if (ch_ramp_active && ch_level > ch_step
                                 && ch_ramp_count < ch_ramp_limit)
                        begin
                            ch_level      = ch_level - ch_step;
                            ch_drive      = ch_level[17:FRAC];
                            ch_ramp_count = ch_ramp_count + 10'd1;
                            ramp_tick_count++;
                        end
                        else
                            clear_channel_state();
                    end
                end
            end
            MODE_START:
            begin
                if (power_cfg > MAX_POWER)
                begin
                    err = 1'b1;
                    refused_count++;
                end
                else if (duration_cfg != 0)
                begin
                    ch_level       = 18'({power_cfg, 3'b000}) << FRAC;
                    ch_step        = (steps == 0) ? '0 : ch_level / steps;
                    ch_ramp_limit  = steps;
                    ch_ramp_count  = '0;
                    ch_ramp_active = ramp_en_cfg;
                    ch_delay       = delay_cfg;
                    ch_duration    = duration_cfg;
                    ch_on          = on_cfg;
                    ch_off         = off_cfg;
                    ch_elapsed     = '0;
                    ch_phase_on    = 1'b1;
                    ch_next_flip   = sat25({2'b00, delay_cfg} + {2'b00, on_cfg});
                    ch_running     = 1'b1;
                    if (delay_cfg == 0)
                        ch_drive = ch_level[17:FRAC];
                end
            end
            default:
            begin
                // both cancels are ignored while the channel is stopped
                if (ch_running)
                begin
                    ch_delay    = '0;
                    ch_duration = '0;
                    if (mode == MODE_CANCEL)
                        ch_ramp_active = 1'b0;
                    else
                    begin
                        ch_ramp_limit  = steps;
                        ch_step        = (steps == 0) ? '0 : ch_level / steps;
                        ch_ramp_count  = '0;
                        ch_ramp_active = 1'b1;
                    end
                end
            end
        endcase
        res.drive_level = ch_drive;
        res.busy_res    = ch_running;
        res.start_error = err;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pulse_result_t got;
        pulse_result_t want;
        int            errs;
        if (!rst_n)
        begin
            delay_cfg    = '0;
            duration_cfg = '0;
            on_cfg       = '0;
            off_cfg      = '0;
            power_cfg    = '0;
            ramp_en_cfg  = 1'b0;
            clear_channel_state();
            drive_expect_q.delete();
            pending         <= 0;
            fail_count      <= 0;
            checked_count   <= 0;
            refused_count   = 0;
            ramp_tick_count = 0;
        end
        else
        begin
            errs = 0;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_DELAY:    delay_cfg    = cfg_data;
                    REG_DURATION: duration_cfg = cfg_data;
                    REG_ON:       on_cfg       = cfg_data;
                    REG_OFF:      off_cfg      = cfg_data;
                    REG_POWER:    power_cfg    = cfg_data[POWER_W-1:0];
                    REG_RAMP_EN:  ramp_en_cfg  = cfg_data[0];
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                drive_expect_q.push_back(predict_pulse_step(mode_t'(s_tuser),
                                                            s_tdata[STEPS_W-1:0]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[OUT_USED_W-1:0];
                if (drive_expect_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: tdata %h", m_tdata);
                    errs++;
                end
                else
                begin
                    want = drive_expect_q.pop_front();
                    checked_count <= checked_count + 1;
                    if (got.drive_level !== want.drive_level)
                    begin
                        $error("drive_level: expected %0d, actual %0d",
                               want.drive_level, got.drive_level);
                        errs++;
                    end
                    if (got.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0d, actual %0d",
                               want.busy_res, got.busy_res);
                        errs++;
                    end
                    if (got.start_error !== want.start_error)
                    begin
                        $error("start_error: expected %0d, actual %0d",
                               want.start_error, got.start_error);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= drive_expect_q.size();
        end
    end

endmodule

### sim/tb_delayed_pulse_train_with_rampdown_core.sv
`timescale 1ns / 100ps

module tb_delayed_pulse_train_with_rampdown_core;

    import dptr_pkg::*;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int RX_HOLD_CYCLES = 300;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [9:0] ramp_steps
    logic [MODE_W-1:0]      s_tuser   = '0;   // [1:0] mode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [9:0] drive_level, [10] busy_res,
                                              // [11] start_error
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [23:0]            cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   checked_count;
    int   refused_count;
    int   ramp_tick_count;

    int   tx_idle_pct    = 0;
    int   rx_idle_pct    = 0;
    logic hold_req       = 1'b0;
    int   stall_left     = 0;
    int   cycle_count    = 0;
    int   items_sent     = 0;
    int   settings_count = 0;

    always #6 clk = ~clk;

    delayed_pulse_train_with_rampdown_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pulse_train_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked_count   (checked_count),
        .refused_count   (refused_count),
        .ramp_tick_count (ramp_tick_count)
    );

    // result side: random back-pressure, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
            stall_left = RX_HOLD_CYCLES;
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // leaves tvalid high after the transfer so the next item can follow at once
    task automatic send_item(input mode_t mode, input logic [STEPS_W-1:0] steps);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= IN_TDATA_W'(steps);
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_count++;
    endtask

    task automatic load_settings(input logic [23:0] delay_len, input logic [23:0] dur_len,
                                 input logic [23:0] on_len, input logic [23:0] off_len,
                                 input logic [POWER_W-1:0] pwr, input logic ramp_on);
        write_reg(REG_DELAY, delay_len);
        write_reg(REG_DURATION, dur_len);
        write_reg(REG_ON, on_len);
        write_reg(REG_OFF, off_len);
        write_reg(REG_POWER, 24'(pwr));
        write_reg(REG_RAMP_EN, 24'(ramp_on));
    endtask

    // mostly short ramps so they finish inside a train, now and then a long one
    function automatic logic [STEPS_W-1:0] ramp_count_pick();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return STEPS_W'($urandom_range(16));
        else if (r < 90)
            return STEPS_W'($urandom_range(63, 17));
        else
            return STEPS_W'($urandom);
    endfunction

    function automatic logic [23:0] phase_len_pick();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 16)
            return '1;
        else
            return 24'($urandom_range(4, 1));
    endfunction

    task automatic random_train(input int n_items);
        int                 r;
        logic [23:0]        delay_len;
        logic [23:0]        dur_len;
        logic [POWER_W-1:0] pwr;
        wait_drained();
        r = $urandom_range(99);
        delay_len = (r < 8) ? 24'hFFFFFF : (r < 16) ? 24'($urandom) : 24'($urandom_range(6));
        r = $urandom_range(99);
        dur_len = (r < 5) ? 24'd0 : (r < 12) ? 24'hFFFFFF :
                  (r < 20) ? 24'($urandom) : 24'($urandom_range(30, 1));
        r = $urandom_range(99);
        pwr = (r < 8) ? POWER_W'($urandom_range(127, 101)) : (r < 15) ? MAX_POWER :
              (r < 20) ? '0 : POWER_W'($urandom_range(99, 1));
        load_settings(delay_len, dur_len, phase_len_pick(), phase_len_pick(), pwr,
                      1'($urandom_range(1)));
        send_item(MODE_START, ramp_count_pick());
        for (int i = 1; i < n_items; i++)
        begin
            r = $urandom_range(99);
            if (r < 6)
                send_item(MODE_START, ramp_count_pick());
            else if (r < 9)
                send_item(MODE_CANCEL, STEPS_W'($urandom));
            else if (r < 12)
                send_item(MODE_CANCEL_RAMP, ramp_count_pick());
            else if (r < 16)
                send_item(mode_t'(2'($urandom_range(3))), STEPS_W'($urandom));
            else
                send_item(MODE_TICK, STEPS_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 33;
        rx_idle_pct <= 47;

        // idle channel, start with zero duration, cancel with nothing running
        send_item(MODE_TICK, 10'h3FF);
        send_item(MODE_START, 10'h3FF);
        send_item(MODE_CANCEL, 10'd0);
        wait_drained();

        // full power, short train, ramp down to the end
        load_settings(24'd0, 24'd3, 24'd1, 24'd1, MAX_POWER, 1'b1);
        send_item(MODE_START, 10'd3);
        repeat (6) send_item(MODE_TICK, 10'd0);
        wait_drained();

        write_reg(REG_POWER, 24'd127);
        send_item(MODE_START, 10'd1);
        wait_drained();
        write_reg(REG_POWER, 24'd101);
        send_item(MODE_START, 10'd1);
        wait_drained();

        // zero on time, ramp straight out of the delay
        load_settings(24'd2, 24'd20, 24'd0, 24'd3, 7'd50, 1'b0);
        send_item(MODE_START, 10'd0);
        send_item(MODE_TICK, 10'd0);
        send_item(MODE_CANCEL_RAMP, 10'd2);
        repeat (3) send_item(MODE_TICK, 10'd0);
        // restart while running, plain cancel, ramp with no steps
        send_item(MODE_START, 10'd7);
        send_item(MODE_TICK, 10'd0);
        send_item(MODE_START, 10'd7);
        send_item(MODE_CANCEL, 10'd0);
        send_item(MODE_TICK, 10'd0);
        send_item(MODE_START, 10'd2);
        send_item(MODE_CANCEL_RAMP, 10'd0);
        send_item(MODE_TICK, 10'd0);

        for (int seg = 0; seg < 3; seg++)
        begin
            wait_drained();
            tx_idle_pct = (seg == 0) ? 33 : (seg == 1) ? 47 : 0;
            rx_idle_pct <= (seg == 0) ? 47 : (seg == 1) ? 33 : 0;
            for (int k = 0; k < 7; k++)
                random_train($urandom_range(60, 40));
        end

        // hold the result side off while ticks keep coming, so the core backs up
        wait_drained();
        load_settings(24'd0, 24'd20, 24'd2, 24'd2, 7'd75, 1'b1);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        send_item(MODE_START, 10'd5);
        repeat (40) send_item(MODE_TICK, STEPS_W'($urandom));
        wait_drained();

        repeat (40) @(posedge clk);
        $display("run covered %0d input transfers and %0d checked results over %0d register writes",
                 items_sent, checked_count, settings_count);
        $display("%0d refused starts, %0d ramp-down steps, one %0d-cycle result hold-off",
                 refused_count, ramp_tick_count, RX_HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
